// ----- hdl/ras_pkg.sv -----
// Shared types and constants for the rhythm activation scorer.
package ras_pkg;

    typedef struct packed {
        logic [23:0] frame_rms;
        logic [23:0] low_band_novelty;
        logic [23:0] mid_band_novelty;
        logic [23:0] high_band_novelty;
        logic [23:0] broadband_novelty;
        logic [23:0] low_band_ratio;
        logic [23:0] tactile_level;
        logic        onset_flag;
        logic [23:0] onset_level;
    } t_in_data;

    typedef struct packed {
        logic        audible;
        logic        acoustic_onset;
        logic [16:0] low_support;
        logic [16:0] activation;
        logic        evidence_event;
    } t_out_data;

    typedef struct packed {
        logic [7:0]  idx;
        logic [23:0] wdata;
    } t_cfg_data;

    localparam logic [7:0]  REG_MIN_RMS = 8'd0;
    localparam logic [7:0]  REG_WARMUP  = 8'd1;

    localparam logic [23:0] MIN_RMS_RST = 24'd66;
    localparam logic [15:0] WARMUP_RST  = 16'd71;

    localparam logic [16:0] ONE_Q16     = 17'd65536;
    localparam logic [16:0] EV_MIN_SUP  = 17'd14418;
    localparam logic [16:0] EV_MIN_RISE = 17'd22938;
    localparam logic [16:0] EV_MIN_ACT  = 17'd13108;

endpackage

// ----- hdl/ras_ifs.sv -----
// Request channels of the rhythm activation scorer: input, result, register write.
interface ras_in_if import ras_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_data data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ras_out_if import ras_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_data data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ras_cfg_if import ras_pkg::*;;
    logic      valid;
    logic      ready;
    t_cfg_data data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/rhythm_activation_scorer.sv -----
// Rhythm activation scorer: per-frame activation score and evidence flag.
//
// Channels: i_in takes one feature frame per request, o_out gives one result
// request per frame, i_cfg writes min_rms (index 0) or warmup_frames (index 1);
// other indexes are ignored. i_cfg is always ready; it is to be written by the
// user only while idle, which the block does not enforce. All handshakes
// complete on a rising i_clk edge with valid and ready high.
// The time from the accepted frame to its result request is set by the shared
// restoring divider (one quotient bit per cycle, after its load state) that
// forms the band share and the three rises in turn; a division whose result
// is known to be zero or saturated ends in the load state with no divide steps.
// The square root of the low-band ratio gives one result bit per cycle beside
// the divider.
// One frame is processed at a time: i_in is ready only when the sequencer idles,
// so a new frame is taken only once the last has reached the output register.
//
// Results sit in an output register; if the receiver stalls, the next frame
// can still be taken and runs until its result waits for the register to free.
// Reset (synchronous, active low) clears the averages and frame counter, loads
// the register defaults and empties the output register.
module rhythm_activation_scorer import ras_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ras_in_if.sink     i_in,
    ras_out_if.source  o_out,
    ras_cfg_if.sink    i_cfg
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PRE   = 4'd1;
    localparam logic [3:0] ST_DLOAD = 4'd2;
    localparam logic [3:0] ST_DIV   = 4'd3;
    localparam logic [3:0] ST_SUP   = 4'd4;
    localparam logic [3:0] ST_GAIN  = 4'd5;
    localparam logic [3:0] ST_ACT   = 4'd6;
    localparam logic [3:0] ST_OUT   = 4'd7;

    // control
    logic [3:0]  r_state;
    logic [1:0]  r_dsel;
    logic [4:0]  r_dcnt;
    logic [4:0]  r_scnt;
    logic        r_ovalid;
    // config and state
    logic [23:0] r_min_rms;
    logic [15:0] r_warmup;
    logic [15:0] r_count;
    logic [31:0] r_avg_r, r_avg_b, r_avg_t;
    // frame payload
    t_in_data    r_in;
    t_out_data   r_odata;
    logic        r_audible, r_warm;
    logic [30:0] r_r22;
    logic [40:0] r_shnum;
    logic [25:0] r_nsum;
    logic [16:0] r_inner;
    // divider
    logic [51:0] r_rem, r_dsh;
    logic [16:0] r_q;
    logic [16:0] r_res [0:3];   // share, spectral, broadband, tactile rise
    // square root
    logic [32:0] r_sv, r_sbit;
    logic [33:0] r_sres;
    // score
    logic [16:0] r_sup, r_sg, r_tg, r_bg;
    logic [16:0] r_sact, r_tact, r_bact, r_oact;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_ovalid;
    assign o_out.data  = r_odata;

    // ---- frame front end: weighted novelty, share numerator, clamps
    logic [40:0] rsum, shnum;
    logic [16:0] rc, ac;
    always_comb begin
        shnum = {r_in.low_band_novelty, 16'b0} + 41'(r_in.mid_band_novelty) * 41'd22938;
        rsum  = shnum + 41'(r_in.high_band_novelty) * 41'd5243;
        rc = (r_in.low_band_ratio > 24'(ONE_Q16)) ? ONE_Q16 : r_in.low_band_ratio[16:0];
        ac = (r_in.onset_level > 24'(ONE_Q16)) ? ONE_Q16 : r_in.onset_level[16:0];
    end

    // ---- divider operand select
    logic [29:0] bb22, t22;
    logic [31:0] diff;
    logic [33:0] dden;
    logic [51:0] dnum;
    logic        dzero, dsat;
    always_comb begin
        bb22  = {r_in.broadband_novelty, 6'b0};
        t22   = {r_in.tactile_level, 6'b0};
        diff  = '0;
        dnum  = '0;
        dden  = '0;
        dzero = 1'b0;
        case (r_dsel)
            2'd0: begin
                dnum  = 52'(r_shnum);
                dden  = 34'(r_nsum);
                dzero = (r_nsum == '0);
            end
            2'd1: begin
                dzero = (32'(r_r22) <= r_avg_r);
                diff  = 32'(r_r22) - r_avg_r;
                dden  = 34'(r_avg_r) + 34'(r_avg_r >> 1) + 34'd6291;
            end
            2'd2: begin
                dzero = (32'(bb22) <= r_avg_b);
                diff  = 32'(bb22) - r_avg_b;
                dden  = 34'(r_avg_b) + {1'b0, r_avg_b, 1'b0} + 34'd12583;
            end
            default: begin
                dzero = (32'(t22) <= r_avg_t);
                diff  = 32'(t22) - r_avg_t;
                dden  = 34'(r_avg_t >> 1) + 34'd4194;
            end
        endcase
        if (r_dsel != 2'd0) dnum = 52'({diff, 16'b0});
        dsat = (dnum >= (52'(dden) << 17));
    end

    // ---- divider step and quotient finish
    logic        qbit;
    logic [16:0] qfin;
    logic [33:0] strial;
    always_comb begin
        qbit   = (r_rem >= r_dsh);
        qfin   = {r_q[15:0], qbit};
        strial = r_sres + 34'(r_sbit);
    end

    // ---- score arithmetic
    logic [33:0] supsum;
    logic [48:0] ema_r, ema_b, ema_t;
    logic [33:0] p_s, p_t, p_b, p_o;
    logic [16:0] amax;
    logic        ev;
    always_comb begin
        supsum = 34'd42598 * 34'(r_sres[16:0]) + 34'd22938 * 34'(r_res[0]) + 34'd32768;
        ema_r  = 49'(r_avg_r) * 49'd64225 + 49'(r_r22) * 49'd1311 + 49'd32768;
        ema_b  = 49'(r_avg_b) * 49'd64225 + 49'(bb22) * 49'd1311 + 49'd32768;
        ema_t  = 49'(r_avg_t) * 49'd64225 + 49'(t22) * 49'd1311 + 49'd32768;
        p_s    = 34'(r_res[1]) * 34'(r_sg) + 34'd32768;
        p_t    = 34'(r_res[3]) * 34'(r_tg) + 34'd32768;
        p_b    = 34'(r_res[2]) * 34'(r_bg) + 34'd32768;
        p_o    = 34'(r_sup) * 34'(r_inner) + 34'd32768;
        amax   = r_sact;
        if (r_tact > amax) amax = r_tact;
        if (r_bact > amax) amax = r_bact;
        if (r_oact > amax) amax = r_oact;
        if (amax > ONE_Q16) amax = ONE_Q16;
        ev = r_audible && !r_warm && (r_sup >= EV_MIN_SUP) &&
             (r_in.onset_flag || r_res[1] >= EV_MIN_RISE || r_res[3] >= EV_MIN_RISE) &&
             (amax >= EV_MIN_ACT);
    end

    // ---- control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_min_rms <= MIN_RMS_RST;
            r_warmup  <= WARMUP_RST;
            r_count   <= '0;
            r_avg_r   <= '0;
            r_avg_b   <= '0;
            r_avg_t   <= '0;
            r_dsel    <= '0;
            r_dcnt    <= '0;
            r_scnt    <= '0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.data.idx)
                    REG_MIN_RMS: r_min_rms <= i_cfg.data.wdata;
                    REG_WARMUP:  r_warmup  <= i_cfg.data.wdata[15:0];
                    default: ;
                endcase
            end
            // the result register reloads from ST_OUT below
            if (o_out.ready && r_state != ST_OUT) r_ovalid <= 1'b0;
            if (r_scnt != '0) r_scnt <= r_scnt - 5'd1;

            case (r_state)
                ST_IDLE: if (i_in.valid) r_state <= ST_PRE;
                ST_PRE: begin
                    if (r_count != 16'hFFFF) r_count <= r_count + 16'd1;
                    r_scnt  <= 5'd17;
                    r_dsel  <= 2'd0;
                    r_state <= ST_DLOAD;
                end
                ST_DLOAD: begin
                    r_dcnt <= 5'd16;
                    if (dzero || dsat) begin
                        r_dsel  <= r_dsel + 2'd1;
                        r_state <= (r_dsel == 2'd3) ? ST_SUP : ST_DLOAD;
                    end else begin
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_dcnt <= r_dcnt - 5'd1;
                    if (r_dcnt == '0) begin
                        r_dsel  <= r_dsel + 2'd1;
                        r_state <= (r_dsel == 2'd3) ? ST_SUP : ST_DLOAD;
                    end
                end
                ST_SUP: if (r_scnt == '0) r_state <= ST_GAIN;
                ST_GAIN: begin
                    r_avg_r <= ema_r[47:16];
                    r_avg_b <= ema_b[47:16];
                    r_avg_t <= ema_t[47:16];
                    r_state <= ST_ACT;
                end
                ST_ACT: r_state <= ST_OUT;
                ST_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ---- datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_in.valid) r_in <= i_in.data;

        if (r_state == ST_PRE) begin
            r_audible <= (r_in.frame_rms >= r_min_rms);
            r_warm    <= (r_count < r_warmup);
            r_r22     <= 31'((rsum + 41'd512) >> 10);
            r_shnum   <= shnum;
            r_nsum    <= 26'(r_in.low_band_novelty) + 26'(r_in.mid_band_novelty)
                       + 26'(r_in.high_band_novelty);
            r_inner   <= 17'd36045 + 17'((18'(ac) + 18'd2) >> 2);
            r_sv      <= {rc, 16'b0};
            r_sres    <= '0;
            r_sbit    <= 33'h1_0000_0000;
        end else if (r_scnt != '0) begin
            // one result bit per cycle, two radicand bits
            if (34'(r_sv) >= strial) begin
                r_sv   <= r_sv - strial[32:0];
                r_sres <= (r_sres >> 1) + 34'(r_sbit);
            end else begin
                r_sres <= r_sres >> 1;
            end
            r_sbit <= r_sbit >> 2;
        end

        if (r_state == ST_DLOAD) begin
            r_rem <= dnum;
            r_dsh <= 52'(dden) << 16;
            r_q   <= '0;
            if (dzero)     r_res[r_dsel] <= '0;
            else if (dsat) r_res[r_dsel] <= ONE_Q16;
        end
        if (r_state == ST_DIV) begin
            if (qbit) r_rem <= r_rem - r_dsh;
            r_dsh <= r_dsh >> 1;
            r_q   <= qfin;
            if (r_dcnt == '0) r_res[r_dsel] <= (qfin > ONE_Q16) ? ONE_Q16 : qfin;
        end

        if (r_state == ST_SUP)
            r_sup <= (supsum[33:16] > 18'(ONE_Q16)) ? ONE_Q16 : supsum[32:16];

        if (r_state == ST_GAIN) begin
            r_sg <= 17'd9830  + 17'((34'd55706 * 34'(r_sup) + 34'd32768) >> 16);
            r_tg <= 17'd16384 + 17'((34'd49152 * 34'(r_sup) + 34'd32768) >> 16);
            r_bg <= 17'd11796 + 17'((34'd13107 * 34'(r_sup) + 34'd32768) >> 16);
        end

        if (r_state == ST_ACT) begin
            r_sact <= p_s[32:16];
            r_tact <= p_t[32:16];
            r_bact <= p_b[32:16];
            r_oact <= r_in.onset_flag ? 17'd6554 + p_o[32:16] : '0;
        end

        if (r_state == ST_OUT && (!r_ovalid || o_out.ready)) begin
            r_odata.audible        <= r_audible;
            r_odata.acoustic_onset <= r_in.onset_flag;
            r_odata.low_support    <= r_sup;
            r_odata.activation     <= (r_audible && !r_warm) ? amax : '0;
            r_odata.evidence_event <= ev;
        end
    end

endmodule

// ----- hdl/ras_checker.sv -----
// Port-level assertions for the rhythm activation scorer, bound to the top level.
module ras_checker import ras_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_data i_out_data
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_data))
        else $error("result payload changed while stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.audible |->
            i_out_data.activation == '0 && !i_out_data.evidence_event)
        else $error("score on inaudible frame");

    a_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.evidence_event |->
            i_out_data.activation >= EV_MIN_ACT && i_out_data.low_support >= EV_MIN_SUP
            && i_out_data.activation <= ONE_Q16)
        else $error("evidence event without enough score");

endmodule

bind rhythm_activation_scorer ras_checker u_ras_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

// ----- dv/rhythm_activation_scorer_test.sv -----
// Self-checking testbench for the rhythm activation scorer: random and directed frames.
module rhythm_activation_scorer_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ras_pkg::*;

    typedef bit [63:0] u64;

    // Register index that the block must ignore.
    localparam logic [7:0] REG_SPARE = 8'hA5;
    // Cycles to let pass before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 120;

    // Scoreboard: own copy of the scorer state, the expected result requests
    // and the mismatch count.
    class score_board;
        bit [23:0]  min_rms;
        bit [15:0]  warmup;
        bit [31:0]  avg_rhythm, avg_bband, avg_tact;
        bit [15:0]  frames;
        t_out_data  exp_q[$];
        int         errors;

        function void clear_state();
            min_rms    = MIN_RMS_RST;
            warmup     = WARMUP_RST;
            avg_rhythm = 0;
            avg_bband  = 0;
            avg_tact   = 0;
            frames     = 0;
        endfunction

        function void write_reg(t_cfg_data w);
            if (w.idx == REG_MIN_RMS) min_rms = w.wdata;
            else if (w.idx == REG_WARMUP) warmup = w.wdata[15:0];
        endfunction

        function u64 sat_one(u64 v);
            return (v > 65536) ? 65536 : v;
        endfunction

        function u64 root(u64 v);
            u64 r, b;
            r = 0;
            b = u64'(1) << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function bit [31:0] smooth(u64 avg, u64 x);
            u64 acc;
            acc = avg * (65536 - 1311) + x * 1311 + 32768;
            return acc[47:16];
        endfunction

        function u64 rel_rise(u64 x, u64 prev, u64 den);
            if (x <= prev) return 0;
            return sat_one(((x - prev) << 16) / den);
        endfunction

        function u64 qmul(u64 a, u64 b);
            u64 p;
            p = a * b + 32768;
            return {32'd0, p[47:16]};
        endfunction

        // Works out the result of one accepted frame and advances the state.
        function void note_frame(t_in_data f);
            u64 lo, md, hi, r22, bb22, t22, nsum, share, rc, s;
            u64 pr, pb, pt, sr, br, tr, sg, tg, bg, oact, act, amp;
            bit aud, ev;
            t_out_data e;
            lo   = f.low_band_novelty;
            md   = f.mid_band_novelty;
            hi   = f.high_band_novelty;
            aud  = f.frame_rms >= min_rms;
            r22  = (lo * 65536 + md * 22938 + hi * 5243 + 512) >> 10;
            bb22 = u64'(f.broadband_novelty) << 6;
            t22  = u64'(f.tactile_level) << 6;
            nsum = lo + md + hi;
            share = (nsum == 0) ? 0 : sat_one((lo * 65536 + md * 22938) / nsum);
            rc = sat_one(f.low_band_ratio);
            s  = sat_one((42598 * root(rc << 16) + 22938 * share + 32768) >> 16);
            // rises are taken against the averages before this frame
            pr = avg_rhythm;
            pb = avg_bband;
            pt = avg_tact;
            avg_rhythm = smooth(pr, r22);
            avg_bband  = smooth(pb, bb22);
            avg_tact   = smooth(pt, t22);
            sr = rel_rise(r22, pr, pr + (pr >> 1) + 6291);
            br = rel_rise(bb22, pb, 3 * pb + 12583);
            tr = rel_rise(t22, pt, (pt >> 1) + 4194);
            sg = 9830 + qmul(55706, s);
            tg = 16384 + qmul(49152, s);
            bg = 11796 + qmul(13107, s);
            act = qmul(sr, sg);
            if (qmul(tr, tg) > act) act = qmul(tr, tg);
            if (qmul(br, bg) > act) act = qmul(br, bg);
            oact = 0;
            if (f.onset_flag) begin
                amp  = sat_one(f.onset_level);
                oact = 6554 + qmul(s, 36045 + qmul(16384, amp));
            end
            if (oact > act) act = oact;
            act = sat_one(act);
            ev = aud && s >= EV_MIN_SUP && act >= EV_MIN_ACT &&
                 (f.onset_flag || sr >= EV_MIN_RISE || tr >= EV_MIN_RISE);
            if (frames < warmup || !aud) begin
                act = 0;
                ev  = 0;
            end
            if (frames != 16'hFFFF) frames++;
            e.audible        = aud;
            e.acoustic_onset = f.onset_flag;
            e.low_support    = s[16:0];
            e.activation     = act[16:0];
            e.evidence_event = ev;
            exp_q.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        task check_result(t_out_data got);
            t_out_data e;
            if (exp_q.size() == 0) begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            e = exp_q.pop_front();
            if (got.audible !== e.audible)
                report($sformatf("audible %b, want %b", got.audible, e.audible));
            if (got.acoustic_onset !== e.acoustic_onset)
                report($sformatf("acoustic_onset %b, want %b",
                                 got.acoustic_onset, e.acoustic_onset));
            if (got.low_support !== e.low_support)
                report($sformatf("low_support %0d, want %0d",
                                 got.low_support, e.low_support));
            if (got.activation !== e.activation)
                report($sformatf("activation %0d, want %0d",
                                 got.activation, e.activation));
            if (got.evidence_event !== e.evidence_event)
                report($sformatf("evidence_event %b, want %b",
                                 got.evidence_event, e.evidence_event));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    ras_in_if  in_if();
    ras_out_if out_if();
    ras_cfg_if cfg_if();

    rhythm_activation_scorer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    score_board sb;
    // Level the random frames wander around; jumps in it make the rises fire.
    int unsigned base_lvl;

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Short gaps mostly, now and then a long one, sometimes none at all.
    function int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Q8.16 field value: mostly near the running level, sometimes anywhere.
    function logic [23:0] pick_q16();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r == 0) return 24'd0;
        if (r == 1) return 24'hFFFFFF;
        if (r < 4) return 24'($urandom_range(0, 24'hFFFFFF));
        if (r < 7) return 24'($urandom_range(0, base_lvl * 6 + 100));
        return 24'($urandom_range(base_lvl / 2, base_lvl + base_lvl / 2 + 10));
    endfunction

    function t_in_data rand_frame();
        t_in_data f;
        if ($urandom_range(0, 15) == 0) base_lvl = $urandom_range(0, 200000);
        f.frame_rms         = ($urandom_range(0, 9) == 0) ? 24'($urandom_range(0, 300))
                                                          : pick_q16();
        f.low_band_novelty  = pick_q16();
        f.mid_band_novelty  = pick_q16();
        f.high_band_novelty = pick_q16();
        f.broadband_novelty = pick_q16();
        f.low_band_ratio    = ($urandom_range(0, 4) == 0) ? pick_q16()
                                                          : 24'($urandom_range(0, 65536));
        f.tactile_level     = pick_q16();
        f.onset_flag        = $urandom_range(0, 3) == 0;
        f.onset_level       = ($urandom_range(0, 2) == 0) ? pick_q16()
                                                          : 24'($urandom_range(0, 65536));
        return f;
    endfunction

    // Sends one frame request; called at a falling edge, returns at one.
    task send_frame(t_in_data f);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= f;
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_frame(f);
        @(negedge i_clk);
    endtask

    // Drops the input valid, lets the block drain, then writes one register.
    task write_reg(logic [7:0] idx, logic [23:0] val);
        in_if.valid <= 1'b0;
        while (sb.exp_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.data.idx  <= idx;
        cfg_if.data.wdata <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        sb.write_reg('{idx: idx, wdata: val});
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task run_random(int n);
        repeat (n) send_frame(rand_frame());
    endtask

    // Directed frame with every novelty field equal to v.
    function t_in_data flat_frame(logic [23:0] rms, logic [23:0] v, logic [23:0] ratio,
                                  logic onset, logic [23:0] amp);
        t_in_data f;
        f = '{rms, v, v, v, v, ratio, v, onset, amp};
        return f;
    endfunction

    // Result side: sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) sb.check_result(out_if.data);
    end

    // Receiver stalls: random on/off stretches, now and then a long clean run.
    initial begin
        int unsigned hold;
        out_if.ready = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                if ($urandom_range(0, 7) == 0) begin
                    out_if.ready <= 1'b1;
                    hold = $urandom_range(50, 200);
                end else begin
                    out_if.ready <= ($urandom_range(0, 2) != 0);
                    hold = pick_gap();
                end
            end else begin
                hold--;
            end
        end
    end

    initial begin
        t_in_data f;
        sb = new();
        sb.clear_state();
        base_lvl  = 20000;
        i_rst_n = 1'b0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Warm-up under the reset settings: activation and evidence held at zero.
        send_frame(flat_frame(24'd70000, 24'd90000, 24'd65536, 1'b1, 24'd65536));
        send_frame(flat_frame(24'd66, 24'd500000, 24'd30000, 1'b0, 24'd0));
        send_frame(flat_frame(24'd65, 24'd0, 24'd0, 1'b1, 24'd0));

        // Directed corners with warm-up over.
        write_reg(REG_MIN_RMS, 24'd1000);
        write_reg(REG_WARMUP, 24'd1);
        write_reg(REG_SPARE, 24'hFFFFFF);           // ignored index
        send_frame(flat_frame(24'd0, 24'd0, 24'd0, 1'b0, 24'd0));
        send_frame(flat_frame(24'd999, 24'd80000, 24'd65536, 1'b1, 24'd65536));
        send_frame(flat_frame(24'd1000, 24'd80000, 24'd65536, 1'b1, 24'd65536));
        send_frame(flat_frame(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 24'hFFFFFF));
        send_frame(flat_frame(24'hFFFFFF, 24'd0, 24'd65537, 1'b1, 24'd0));   // zero band sum
        send_frame(flat_frame(24'hFFFFFF, 24'd0, 24'd0, 1'b0, 24'd0));       // below averages
        send_frame(flat_frame(24'd70000, 24'd1, 24'd1, 1'b0, 24'd1));
        f = flat_frame(24'd70000, 24'd0, 24'd65536, 1'b0, 24'd0);
        f.low_band_novelty = 24'd300000;                                     // low band only
        send_frame(f);
        f.low_band_novelty = 24'd0;
        f.mid_band_novelty = 24'hFFFFFF;                                     // mid band only
        send_frame(f);
        f.mid_band_novelty  = 24'd0;
        f.high_band_novelty = 24'hFFFFFF;                                    // high band only
        send_frame(f);
        f = flat_frame(24'd70000, 24'd0, 24'd40000, 1'b0, 24'd0);
        f.tactile_level = 24'd400000;                                        // tactile rise
        send_frame(f);
        f.tactile_level     = 24'd0;
        f.broadband_novelty = 24'hFFFFFF;                                    // broadband rise
        send_frame(f);
        send_frame(flat_frame(24'd70000, 24'd0, 24'd0, 1'b1, 24'hFFFFFF));   // onset, no support
        send_frame(flat_frame(24'd70000, 24'd0, 24'd65536, 1'b1, 24'd32768));
        send_frame(flat_frame(24'd70000, 24'h555555, 24'hAAAAAA, 1'b1, 24'h555555));
        send_frame(flat_frame(24'd70000, 24'hAAAAAA, 24'h555555, 1'b0, 24'hAAAAAA));

        // Reset settings written back; the first random frames fall in warm-up again.
        write_reg(REG_MIN_RMS, MIN_RMS_RST);
        write_reg(REG_WARMUP, 24'(WARMUP_RST));
        run_random(400);

        // Lowest threshold; warm-up ends partway through this phase.
        write_reg(REG_MIN_RMS, 24'd0);
        write_reg(REG_WARMUP, 24'(sb.frames + 16'd20));
        run_random(400);

        // Highest settings: almost nothing audible, everything in warm-up.
        write_reg(REG_MIN_RMS, 24'hFFFFFF);
        write_reg(REG_WARMUP, 24'hFFFF);
        run_random(100);

        write_reg(REG_MIN_RMS, 24'($urandom_range(0, 200000)));
        write_reg(REG_WARMUP, 24'd1);
        run_random(300);

        in_if.valid <= 1'b0;
        while (sb.exp_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20ms;
        $display("watchdog expired, %0d results outstanding", sb.exp_q.size());
        $display("CHECK FAILED");
        $finish;
    end
endmodule
